>>> hw/rtl/meter_readout_sequencer_core_macros.svh
// Assertion macros used by the checker file of the readout sequencer.
`ifndef METER_READOUT_SEQUENCER_CORE_MACROS_SVH
`define METER_READOUT_SEQUENCER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MRS_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("readout sequencer check failed");

// A condition that, once seen, must be followed by another in the next cycle.
`define MRS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("readout sequencer check failed");

`endif

>>> hw/rtl/mrs_pkg.sv
// Types, codes, constants and lookup functions of the meter readout sequencer.
package mrs_pkg;

  localparam int unsigned IDENT_MAX_DEF   = 32;
  localparam int unsigned LINE_MAX_DEF    = 128;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [14:0] BAUD_RESET = 15'd300;

  localparam logic [7:0] CHR_STX   = 8'h02;
  localparam logic [7:0] CHR_ETX   = 8'h03;
  localparam logic [7:0] CHR_ACK   = 8'h06;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_QUEST = 8'h3F;
  localparam logic [7:0] CHR_EXCL  = 8'h21;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_SIX   = 8'h36;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_F     = 8'h46;

  localparam logic [7:0] IDENT_MIN = 8'd6;
  localparam logic [7:0] SPEED_POS = 8'd5;
  localparam logic [7:0] LINE_MIN  = 8'd2;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RX      = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_BAUD = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OC_OK    = 2'd0,
    OC_PROTO = 2'd1,
    OC_BCC   = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_IDENT = 2'd1,
    PH_DATA  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_e;

  // What the front hands to the back: one job expands into one or more words.
  typedef enum logic [1:0] {
    JOB_REQUEST = 2'd0,
    JOB_ACK     = 2'd1,
    JOB_BAUD    = 2'd2,
    JOB_FINISH  = 2'd3
  } job_type_e;

  typedef struct packed {
    job_type_e   jtype;
    logic [7:0]  speed;
    logic [14:0] baud;
    outcome_e    outcome;
  } job_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic [14:0] baud_rate;
    outcome_e    outcome;
    logic        last;
  } result_t;

  // Baud rate for a speed index, 0 is 300 up to 6 is 19200.
  function automatic logic [14:0] rate_of(logic [7:0] idx);
    logic [14:0] r;
    case (idx)
      8'd0:    r = 15'd300;
      8'd1:    r = 15'd600;
      8'd2:    r = 15'd1200;
      8'd3:    r = 15'd2400;
      8'd4:    r = 15'd4800;
      8'd5:    r = 15'd9600;
      8'd6:    r = 15'd19200;
      default: r = 15'd300;
    endcase
    return r;
  endfunction

  // Bytes of the sign-on request "/?!" CR LF.
  function automatic logic [7:0] request_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CHR_SLASH;
      3'd1:    b = CHR_QUEST;
      3'd2:    b = CHR_EXCL;
      3'd3:    b = CHR_CR;
      default: b = CHR_LF;
    endcase
    return b;
  endfunction

  // Bytes of the acknowledge message ACK '0' speed '0' CR LF.
  function automatic logic [7:0] ack_byte(logic [2:0] idx, logic [7:0] speed);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CHR_ACK;
      3'd1:    b = CHR_ZERO;
      3'd2:    b = speed;
      3'd3:    b = CHR_ZERO;
      3'd4:    b = CHR_CR;
      default: b = CHR_LF;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/meter_readout_sequencer_core.sv
// Top level of the meter readout sequencer: front, job queue and back end.
//
// Usage. The slave stream takes one word per event: tuser carries the opcode
// (start, received byte, receive timeout) and tdata the received byte. The
// master stream gives the sequencer's words: tuser is the kind (transmit
// byte, set receive baud, readout finished), tdata packs the byte, the baud
// rate, the outcome and the three wrapping totals, and tlast marks the final
// word caused by one input word. cfg_we_i writes the initial baud rate; the
// user must write it only while the block is idle; the block does not enforce it.
// Timing. The front classifies an input word in the cycle it is accepted and
// places at most one job in a four-entry queue; s_axis_tready is low only
// while that queue is full. The back end turns a job into one to seven words
// at one word per cycle while the receiver is ready; its first word passes
// through the queue and the output register before it is on offer. Sustained
// throughput is one input word per cycle for words that cause at most one
// result while the receiver is ready; the back end's one-word-per-cycle
// output register bounds the rest.
// Reset clears the phase to idle, all totals to zero and the initial baud
// rate to 300. When the receiver stalls, the output word holds and the queue
// fills; the input side keeps accepting until the queue is full.
module meter_readout_sequencer_core #(
  parameter int unsigned IdentMax   = mrs_pkg::IDENT_MAX_DEF,
  parameter int unsigned LineMax    = mrs_pkg::LINE_MAX_DEF,
  parameter int unsigned QueueDepth = mrs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]   s_axis_tuser,   // [1:0] opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] tx_byte, [22:8] baud_rate, [24:23] outcome, [56:25] ok_count,
  // [88:57] protocol_error_count, [120:89] checksum_error_count, rest zero
  output logic [127:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i
);

  logic [14:0]      init_baud_q;
  logic             in_accept;
  logic             q_push;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  mrs_pkg::job_t    q_in;
  mrs_pkg::job_t    q_out;
  mrs_pkg::result_t res;
  logic [31:0]      ok_cnt;
  logic [31:0]      pe_cnt;
  logic [31:0]      ce_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_baud_q <= mrs_pkg::BAUD_RESET;
    end else if (cfg_we_i) begin
      init_baud_q <= cfg_wdata_i;
    end
  end

  // The front never waits on anything but queue space.
  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  mrs_front #(
    .IdentMax (IdentMax),
    .LineMax  (LineMax)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .opcode_i       (s_axis_tuser),
    .rx_byte_i      (s_axis_tdata),
    .initial_baud_i (init_baud_q),
    .push_o         (q_push),
    .job_o          (q_in)
  );

  mrs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  mrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (q_out),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .ok_cnt_o    (ok_cnt),
    .proto_cnt_o (pe_cnt),
    .bcc_cnt_o   (ce_cnt)
  );

  assign m_axis_tdata = {7'd0, ce_cnt, pe_cnt, ok_cnt, res.outcome, res.baud_rate,
                         res.tx_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

>>> hw/rtl/mrs_fifo.sv
// Short job queue between the classifying front and the result-emitting back.
module mrs_fifo #(
  parameter int unsigned Depth = mrs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrs_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mrs_pkg::job_t data_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mrs_pkg::job_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

>>> hw/rtl/mrs_front.sv
// Protocol front: tracks the readout phase per received word and queues jobs.
module mrs_front #(
  parameter int unsigned IdentMax = mrs_pkg::IDENT_MAX_DEF,
  parameter int unsigned LineMax  = mrs_pkg::LINE_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [1:0]    opcode_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [14:0]   initial_baud_i,
  output logic          push_o,
  output mrs_pkg::job_t job_o
);

  mrs_pkg::phase_e phase_q, phase_d;
  logic [7:0] check_q, check_d;
  logic [7:0] lc_q, lc_d;
  logic [7:0] prev_q, prev_d;
  logic [7:0] pprev_q, pprev_d;
  logic [7:0] speed_q, speed_d;
  logic [7:0] tfirst_q, tfirst_d;
  logic       tseen_q, tseen_d;

  logic [7:0] lc_inc;
  logic [7:0] lc_eval;
  logic [7:0] speed_eval;
  logic [7:0] check_x;
  logic       ident_end;
  logic       data_end;
  logic       fin;
  mrs_pkg::outcome_e fin_oc;
  logic       is_rx;
  logic       is_to;
  logic       line_brk;

  assign lc_inc   = lc_q + 8'd1;
  assign is_rx    = (opcode_i == mrs_pkg::OP_RX);
  assign is_to    = (opcode_i == mrs_pkg::OP_TIMEOUT);
  assign line_brk = is_to || (rx_byte_i == mrs_pkg::CHR_LF);

  always_comb begin
    phase_d    = phase_q;
    check_d    = check_q;
    lc_d       = lc_q;
    prev_d     = prev_q;
    pprev_d    = pprev_q;
    speed_d    = speed_q;
    tfirst_d   = tfirst_q;
    tseen_d    = tseen_q;
    push_o     = 1'b0;
    job_o      = '0;
    ident_end  = 1'b0;
    data_end   = 1'b0;
    lc_eval    = lc_q;
    speed_eval = speed_q;
    check_x    = check_q;
    fin        = 1'b0;
    fin_oc     = mrs_pkg::OC_PROTO;

    if (accept_i) begin
      unique case (phase_q)
        mrs_pkg::PH_IDLE: begin
          if (opcode_i == mrs_pkg::OP_START) begin
            push_o        = 1'b1;
            job_o.jtype   = mrs_pkg::JOB_REQUEST;
            job_o.baud    = initial_baud_i;
            phase_d       = mrs_pkg::PH_IDENT;
            lc_d          = '0;
            tseen_d       = 1'b0;
          end
        end
        mrs_pkg::PH_IDENT: begin
          if (is_rx || is_to) begin
            if (line_brk) begin
              ident_end = 1'b1;
            end else begin
              lc_d    = lc_inc;
              lc_eval = lc_inc;
              if (lc_inc == mrs_pkg::SPEED_POS) begin
                speed_d    = rx_byte_i;
                speed_eval = rx_byte_i;
              end
              ident_end = (lc_inc >= 8'(IdentMax));
            end
          end
          if (ident_end) begin
            if (lc_eval < mrs_pkg::IDENT_MIN) begin
              fin = 1'b1;
            end else begin
              push_o = 1'b1;
              if (speed_eval >= mrs_pkg::CHR_ZERO && speed_eval <= mrs_pkg::CHR_SIX) begin
                job_o.jtype = mrs_pkg::JOB_ACK;
                job_o.speed = speed_eval;
                job_o.baud  = mrs_pkg::rate_of(speed_eval - mrs_pkg::CHR_ZERO);
              end else if (speed_eval >= mrs_pkg::CHR_A && speed_eval <= mrs_pkg::CHR_F) begin
                job_o.jtype = mrs_pkg::JOB_BAUD;
                job_o.baud  = mrs_pkg::rate_of(speed_eval - mrs_pkg::CHR_A + 8'd1);
              end else begin
                job_o.jtype = mrs_pkg::JOB_BAUD;
                job_o.baud  = initial_baud_i;
              end
              phase_d = mrs_pkg::PH_DATA;
              check_d = mrs_pkg::CHR_STX;
              lc_d    = '0;
            end
          end
        end
        mrs_pkg::PH_DATA: begin
          if (is_rx || is_to) begin
            if (line_brk) begin
              if (lc_q < mrs_pkg::LINE_MIN) begin
                fin = 1'b1;
              end else begin
                data_end = 1'b1;
              end
            end else begin
              check_x = check_q ^ rx_byte_i;
              check_d = check_x;
              pprev_d = prev_q;
              prev_d  = rx_byte_i;
              lc_d    = lc_inc;
              data_end = (lc_inc >= 8'(LineMax));
            end
          end
          // A line that ends adds the LF to the check byte; "!" before the
          // line end marks the last data line.
          if (data_end) begin
            check_d = check_x ^ mrs_pkg::CHR_LF;
            lc_d    = '0;
            if (pprev_d == mrs_pkg::CHR_EXCL) begin
              phase_d = mrs_pkg::PH_TRAIL;
              tseen_d = 1'b0;
            end
          end
        end
        mrs_pkg::PH_TRAIL: begin
          if (is_to) begin
            fin = 1'b1;
          end else if (is_rx) begin
            if (!tseen_q) begin
              tfirst_d = rx_byte_i;
              tseen_d  = 1'b1;
            end else if (tfirst_q != mrs_pkg::CHR_ETX) begin
              fin = 1'b1;
            end else begin
              check_x = check_q ^ mrs_pkg::CHR_ETX;
              check_d = check_x;
              fin     = 1'b1;
              fin_oc  = (check_x == rx_byte_i) ? mrs_pkg::OC_OK : mrs_pkg::OC_BCC;
            end
          end
        end
        default: ;
      endcase

      if (fin) begin
        push_o        = 1'b1;
        job_o         = '0;
        job_o.jtype   = mrs_pkg::JOB_FINISH;
        job_o.outcome = fin_oc;
        phase_d       = mrs_pkg::PH_IDLE;
        lc_d          = '0;
        tseen_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mrs_pkg::PH_IDLE;
      check_q  <= '0;
      lc_q     <= '0;
      prev_q   <= '0;
      pprev_q  <= '0;
      speed_q  <= '0;
      tfirst_q <= '0;
      tseen_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      check_q  <= check_d;
      lc_q     <= lc_d;
      prev_q   <= prev_d;
      pprev_q  <= pprev_d;
      speed_q  <= speed_d;
      tfirst_q <= tfirst_d;
      tseen_q  <= tseen_d;
    end
  end

endmodule

>>> hw/rtl/mrs_back.sv
// Result back end: expands queued jobs into output words and keeps the totals.
module mrs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  mrs_pkg::job_t     job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mrs_pkg::result_t  out_o,
  output logic [31:0]       ok_cnt_o,
  output logic [31:0]       proto_cnt_o,
  output logic [31:0]       bcc_cnt_o
);

  logic [2:0]       idx_q, idx_d;
  logic             vld_q, vld_d;
  mrs_pkg::result_t out_q, res;
  logic [31:0]      ok_q, ok_d;
  logic [31:0]      pe_q, pe_d;
  logic [31:0]      ce_q, ce_d;
  logic             load;

  assign load = job_valid_i && (!vld_q || out_ready_i);

  // Word number idx of the job at the head of the queue.
  always_comb begin
    res = '0;
    unique case (job_i.jtype)
      mrs_pkg::JOB_REQUEST: begin
        if (idx_q < 3'd5) begin
          res.kind    = mrs_pkg::KIND_TX;
          res.tx_byte = mrs_pkg::request_byte(idx_q);
        end else begin
          res.kind      = mrs_pkg::KIND_BAUD;
          res.baud_rate = job_i.baud;
          res.last      = 1'b1;
        end
      end
      mrs_pkg::JOB_ACK: begin
        if (idx_q < 3'd6) begin
          res.kind    = mrs_pkg::KIND_TX;
          res.tx_byte = mrs_pkg::ack_byte(idx_q, job_i.speed);
        end else begin
          res.kind      = mrs_pkg::KIND_BAUD;
          res.baud_rate = job_i.baud;
          res.last      = 1'b1;
        end
      end
      mrs_pkg::JOB_BAUD: begin
        res.kind      = mrs_pkg::KIND_BAUD;
        res.baud_rate = job_i.baud;
        res.last      = 1'b1;
      end
      mrs_pkg::JOB_FINISH: begin
        res.kind    = mrs_pkg::KIND_DONE;
        res.outcome = job_i.outcome;
        res.last    = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    ok_d  = ok_q;
    pe_d  = pe_q;
    ce_d  = ce_q;
    pop_o = 1'b0;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (load) begin
      vld_d = 1'b1;
      if (res.last) begin
        idx_d = '0;
        pop_o = 1'b1;
      end else begin
        idx_d = idx_q + 3'd1;
      end
      if (res.kind == mrs_pkg::KIND_DONE) begin
        case (res.outcome)
          mrs_pkg::OC_OK:    ok_d = ok_q + 32'd1;
          mrs_pkg::OC_PROTO: pe_d = pe_q + 32'd1;
          default:           ce_d = ce_q + 32'd1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
      ok_q  <= '0;
      pe_q  <= '0;
      ce_q  <= '0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
      ok_q  <= ok_d;
      pe_q  <= pe_d;
      ce_q  <= ce_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = out_q;
  // The totals change only when a new word is loaded, so they always match
  // the word that is on offer.
  assign ok_cnt_o    = ok_q;
  assign proto_cnt_o = pe_q;
  assign bcc_cnt_o   = ce_q;

endmodule

>>> hw/rtl/mrs_checker.sv
// Port-level checks of the readout sequencer's output stream, bound to the top.
`include "meter_readout_sequencer_core_macros.svh"

module mrs_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast
);

  logic stalled;
  logic is_tx;
  logic is_done;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign is_tx   = (m_axis_tuser == mrs_pkg::KIND_TX);
  assign is_done = (m_axis_tuser == mrs_pkg::KIND_DONE);

  // A stalled word stays on offer with its tdata unchanged.
  `MRS_ASSERT_NEXT(a_stall_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata))

  // A finished readout is always the final word of its input.
  `MRS_ASSERT(a_done_last, !m_axis_tvalid || !is_done || m_axis_tlast)

  // A transmit byte never ends an input's burst: the baud word follows it.
  `MRS_ASSERT(a_tx_not_last, !m_axis_tvalid || !is_tx || !m_axis_tlast)

  // Only transmit words carry a byte.
  `MRS_ASSERT(a_tx_byte_zero, !m_axis_tvalid || is_tx || m_axis_tdata[7:0] == 8'd0)

  // Only finish words carry an outcome.
  `MRS_ASSERT(a_outcome_zero, !m_axis_tvalid || is_done || m_axis_tdata[24:23] == 2'd0)

endmodule

bind meter_readout_sequencer_core mrs_checker u_mrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/mrs_tb_pkg.sv
// Self-checking model of the meter readout sequencer, used by the testbench.
`timescale 1ns / 100ps

package mrs_tb_pkg;
  import mrs_pkg::*;

  localparam logic [14:0] BAUD_BY_SPEED [7] = '{
    15'd300, 15'd600, 15'd1200, 15'd2400, 15'd4800, 15'd9600, 15'd19200
  };

  typedef struct {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic [14:0] baud;
    outcome_e    outcome;
    logic [31:0] ok_n;
    logic [31:0] proto_n;
    logic [31:0] bcc_n;
    logic        last;
  } readout_word_t;

  class readout_tracker;
    logic [14:0]   init_baud;
    phase_e        phase;
    logic [7:0]    check_byte;
    logic [7:0]    line_len;
    logic [7:0]    prev_byte;
    logic [7:0]    prev_prev_byte;
    logic [7:0]    speed_char;
    logic [7:0]    trailer_first;
    bit            trailer_seen;
    logic [31:0]   ok_total;
    logic [31:0]   proto_total;
    logic [31:0]   bcc_total;
    readout_word_t burst[$];
    readout_word_t awaited_words[$];
    int unsigned   errors;
    int unsigned   events_taken;
    int unsigned   events_used;
    int unsigned   words_checked;

    function new();
      init_baud      = BAUD_RESET;
      phase          = PH_IDLE;
      check_byte     = '0;
      line_len       = '0;
      prev_byte      = '0;
      prev_prev_byte = '0;
      speed_char     = '0;
      trailer_first  = '0;
      trailer_seen   = 1'b0;
      ok_total       = '0;
      proto_total    = '0;
      bcc_total      = '0;
      errors         = 0;
      events_taken   = 0;
      events_used    = 0;
      words_checked  = 0;
    endfunction

    function int unsigned pending();
      return awaited_words.size();
    endfunction

    // Second trailer byte that makes the current readout pass.
    function logic [7:0] closing_bcc();
      return check_byte ^ CHR_ETX;
    endfunction

    function void emit(kind_e kind, logic [7:0] tx, logic [14:0] baud, outcome_e oc);
      readout_word_t w;
      w.kind    = kind;
      w.tx_byte = tx;
      w.baud    = baud;
      w.outcome = oc;
      w.ok_n    = ok_total;
      w.proto_n = proto_total;
      w.bcc_n   = bcc_total;
      w.last    = 1'b0;
      burst.push_back(w);
    endfunction

    // Totals are bumped before the word is built, so it carries the new count.
    function void finish_readout(outcome_e oc);
      case (oc)
        OC_OK:    ok_total++;
        OC_PROTO: proto_total++;
        default:  bcc_total++;
      endcase
      phase        = PH_IDLE;
      line_len     = '0;
      trailer_seen = 1'b0;
      emit(KIND_DONE, 8'h00, 15'd0, oc);
    endfunction

    function void close_ident();
      logic [14:0] baud;
      baud = init_baud;
      if (line_len < IDENT_MIN) begin
        finish_readout(OC_PROTO);
        return;
      end
      if (speed_char >= CHR_ZERO && speed_char <= CHR_SIX) begin
        emit(KIND_TX, CHR_ACK, 15'd0, OC_OK);
        emit(KIND_TX, CHR_ZERO, 15'd0, OC_OK);
        emit(KIND_TX, speed_char, 15'd0, OC_OK);
        emit(KIND_TX, CHR_ZERO, 15'd0, OC_OK);
        emit(KIND_TX, CHR_CR, 15'd0, OC_OK);
        emit(KIND_TX, CHR_LF, 15'd0, OC_OK);
        baud = BAUD_BY_SPEED[speed_char - CHR_ZERO];
      end else if (speed_char >= CHR_A && speed_char <= CHR_F) begin
        baud = BAUD_BY_SPEED[speed_char - CHR_A + 8'd1];
      end
      emit(KIND_BAUD, 8'h00, baud, OC_OK);
      phase      = PH_DATA;
      check_byte = CHR_STX;
      line_len   = '0;
    endfunction

    // A line cut short by LF or timeout needs two bytes; a full line does not.
    function void close_line(bit full);
      if (!full && line_len < LINE_MIN) begin
        finish_readout(OC_PROTO);
        return;
      end
      check_byte ^= CHR_LF;
      if (prev_prev_byte == CHR_EXCL) begin
        phase        = PH_TRAIL;
        trailer_seen = 1'b0;
      end
      line_len = '0;
    endfunction

    // Called once per accepted input word; queues the words it must cause.
    function void take_event(opcode_e op, logic [7:0] b);
      bit act;
      act = (op == OP_RX || op == OP_TIMEOUT);
      burst.delete();
      events_taken++;
      if (phase == PH_IDLE) begin
        if (op == OP_START) begin
          events_used++;
          emit(KIND_TX, CHR_SLASH, 15'd0, OC_OK);
          emit(KIND_TX, CHR_QUEST, 15'd0, OC_OK);
          emit(KIND_TX, CHR_EXCL, 15'd0, OC_OK);
          emit(KIND_TX, CHR_CR, 15'd0, OC_OK);
          emit(KIND_TX, CHR_LF, 15'd0, OC_OK);
          emit(KIND_BAUD, 8'h00, init_baud, OC_OK);
          phase        = PH_IDENT;
          line_len     = '0;
          trailer_seen = 1'b0;
        end
      end else if (act) begin
        events_used++;
        case (phase)
          PH_IDENT: begin
            if (op == OP_TIMEOUT || b == CHR_LF) begin
              close_ident();
            end else begin
              line_len++;
              if (line_len == SPEED_POS) speed_char = b;
              if (line_len >= IDENT_MAX_DEF) close_ident();
            end
          end
          PH_DATA: begin
            if (op == OP_TIMEOUT || b == CHR_LF) begin
              close_line(1'b0);
            end else begin
              check_byte    ^= b;
              prev_prev_byte = prev_byte;
              prev_byte      = b;
              line_len++;
              if (line_len >= LINE_MAX_DEF) close_line(1'b1);
            end
          end
          default: begin
            if (op == OP_TIMEOUT) begin
              finish_readout(OC_PROTO);
            end else if (!trailer_seen) begin
              trailer_first = b;
              trailer_seen  = 1'b1;
            end else if (trailer_first != CHR_ETX) begin
              finish_readout(OC_PROTO);
            end else begin
              check_byte ^= CHR_ETX;
              finish_readout((check_byte == b) ? OC_OK : OC_BCC);
            end
          end
        endcase
      end
      foreach (burst[i]) begin
        readout_word_t w;
        w      = burst[i];
        w.last = (i == burst.size() - 1);
        awaited_words.push_back(w);
      end
    endfunction

    function void match(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [1:0] user, logic [127:0] data, logic last);
      readout_word_t w;
      words_checked++;
      if (awaited_words.size() == 0) begin
        $error("output word with nothing awaited: tuser 0x%0h tdata 0x%0h", user, data);
        errors++;
        return;
      end
      w = awaited_words.pop_front();
      match("kind", 32'(w.kind), 32'(user));
      match("tx_byte", 32'(w.tx_byte), 32'(data[7:0]));
      match("baud_rate", 32'(w.baud), 32'(data[22:8]));
      match("outcome", 32'(w.outcome), 32'(data[24:23]));
      match("ok_count", w.ok_n, data[56:25]);
      match("protocol_error_count", w.proto_n, data[88:57]);
      match("checksum_error_count", w.bcc_n, data[120:89]);
      match("tdata padding", 32'd0, 32'(data[127:121]));
      match("last", 32'(w.last), 32'(last));
    endfunction
  endclass

endpackage

>>> tb/tb.sv
// Testbench top: drives readout sequences into the sequencer and checks every output word.
`timescale 1ns / 100ps

module tb;
  import mrs_pkg::*;
  import mrs_tb_pkg::*;

  // Random readouts stop once about this many input words have been sent in all.
  localparam int unsigned EVENT_GOAL    = 300;
  localparam int unsigned PHASES        = 6;
  // Cycles allowed after the last awaited word before touching the baud register.
  localparam int unsigned SETTLE_CYCLES = 32;
  // Length of the one long receiver stall that fills the job queue.
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i;
  logic [14:0]  cfg_wdata_i;

  readout_tracker sb;
  bit             quiet;      // no idling on either side in the last phase
  bit             hold_req;   // asks the receiver for its long stall
  bit             hold_done;  // set by the receiver once that stall is over
  int unsigned    cycle_count;
  logic [14:0]    baud_plan [PHASES];

  meter_readout_sequencer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake or a missing word ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver side. It idles in short random bursts, and once on request it
  // holds tready low for a long stretch so that the job queue fills and the
  // block has to refuse input. The ready change always lands on a falling edge.
  always begin
    @(negedge clk_i);
    if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_done = 1'b1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  // Output monitor: every accepted word is compared with the oldest one awaited.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  // Offers one input word, maybe after a short gap, and waits for acceptance.
  // tvalid stays high on return, so back-to-back words need not drop it in between.
  task automatic send_word(input opcode_e op, input logic [7:0] b);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_event(op, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_RX, s[i]);
  endtask

  // Stops offering input and waits until every awaited word has come out,
  // then a little longer for words that cause nothing.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_initial_baud(input logic [14:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.init_baud = v;
  endtask

  // Data byte that never ends a line and, unless allow_excl is set, is not the end-of-data mark.
  function automatic logic [7:0] text_byte(input bit allow_excl);
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == CHR_LF || (!allow_excl && b == CHR_EXCL));
    return b;
  endfunction

  // Fifth identification byte: an acknowledged speed, a plain speed letter
  // or a random text byte, which mostly keeps the initial baud rate.
  function automatic logic [7:0] pick_speed();
    case ($urandom_range(0, 2))
      0:       return CHR_ZERO + 8'($urandom_range(0, 6));
      1:       return CHR_A + 8'($urandom_range(0, 5));
      default: return text_byte(1'b1);
    endcase
  endfunction

  // Timeouts end the readout whatever phase it was left in.
  task automatic close_out();
    while (sb.phase != PH_IDLE) send_word(OP_TIMEOUT, 8'($urandom));
  endtask

  // One readout. Most are well formed with random content; a few break at a
  // chosen point, and one kind is pure noise after the start word.
  task automatic run_readout();
    int unsigned style;
    int unsigned len;
    int unsigned lines;
    bit          final_line;
    logic [7:0]  speed;
    logic [7:0]  b;
    style = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) begin
      // Words that an idle block must ignore.
      repeat ($urandom_range(1, 3)) begin
        send_word(opcode_e'($urandom_range(OP_RX, OP_NONE)), 8'($urandom));
      end
    end
    send_word(OP_START, 8'($urandom));
    if (style == 8) begin
      repeat ($urandom_range(2, 12)) begin
        send_word(opcode_e'($urandom_range(OP_RX, OP_NONE)), 8'($urandom));
      end
      close_out();
      return;
    end

    // Identification line: too short, as long as allowed, or ordinary.
    case (style)
      0:       len = $urandom_range(0, 5);
      1:       len = IDENT_MAX_DEF;
      default: len = $urandom_range(6, 12);
    endcase
    speed = pick_speed();
    for (int i = 1; i <= len; i++) begin
      send_word(OP_RX, (i == SPEED_POS) ? speed : text_byte(1'b1));
    end
    if (len < IDENT_MAX_DEF) begin
      if (style == 2) send_word(OP_TIMEOUT, 8'($urandom));
      else send_word(OP_RX, CHR_LF);
    end
    if ($urandom_range(0, 9) == 0) begin
      // An unused opcode here is ignored, and so is a start unless the readout ended early.
      send_word(($urandom_range(0, 1) != 0) ? OP_START : OP_NONE, 8'($urandom));
    end

    // Data lines; the last one carries the end-of-data mark unless it is cut short on purpose.
    lines = $urandom_range(1, 4);
    for (int l = 0; l < lines; l++) begin
      if (sb.phase != PH_DATA) break;
      final_line = (l == lines - 1);
      if (style == 3 && final_line) begin
        len = $urandom_range(0, 1);
        repeat (len) send_word(OP_RX, text_byte(1'b0));
        send_word(($urandom_range(0, 1) != 0) ? OP_TIMEOUT : OP_RX, CHR_LF);
      end else begin
        len = (style == 4 && l == 0) ? LINE_MAX_DEF : $urandom_range(2, 10);
        for (int i = 0; i < len; i++) begin
          if (final_line && i == len - 2) b = CHR_EXCL;
          else if (final_line && i == len - 1) b = CHR_CR;
          else b = text_byte(1'b0);
          send_word(OP_RX, b);
        end
        // A full line closes by itself; others end on LF or a timeout.
        if (len < LINE_MAX_DEF) begin
          if ($urandom_range(0, 5) == 0) send_word(OP_TIMEOUT, 8'($urandom));
          else send_word(OP_RX, CHR_LF);
        end
      end
    end

    // Trailer: ETX and the check byte, or one of the ways it goes wrong.
    if (sb.phase == PH_TRAIL) begin
      case (style)
        5: begin
          if ($urandom_range(0, 1) != 0) send_word(OP_RX, CHR_ETX);
          send_word(OP_TIMEOUT, 8'($urandom));
        end
        6: begin
          do begin
            b = 8'($urandom);
          end while (b == CHR_ETX);
          send_word(OP_RX, b);
          send_word(OP_RX, 8'($urandom));
        end
        7: begin
          send_word(OP_RX, CHR_ETX);
          send_word(OP_RX, sb.closing_bcc() ^ 8'($urandom_range(1, 255)));
        end
        default: begin
          send_word(OP_RX, CHR_ETX);
          send_word(OP_RX, sb.closing_bcc());
        end
      endcase
    end
    close_out();
  endtask

  initial begin
    int unsigned goal;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_NONE;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    cycle_count   = 0;
    baud_plan     = '{15'h7FFF, 15'd0, 15'd19200, 15'd300, 15'd300, 15'd0};
    baud_plan[4]  = 15'($urandom_range(300, 19200));
    baud_plan[5]  = 15'($urandom);
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, at the reset baud rate. Idle words are dropped, a
    // timeout during identification gives a protocol error, and then one
    // clean readout with an acknowledged top speed and a stray start and
    // unused opcode in the middle closes with a good check byte.
    send_word(OP_NONE, 8'hFF);
    send_word(OP_RX, 8'h00);
    send_word(OP_TIMEOUT, 8'hA5);
    send_word(OP_START, 8'h00);
    send_word(OP_TIMEOUT, 8'hFF);
    send_word(OP_START, 8'hFF);
    send_text("/XYZ6Q\n");
    send_word(OP_START, 8'h5A);
    send_word(OP_NONE, 8'h00);
    send_text("!\r\n");
    send_word(OP_RX, CHR_ETX);
    send_word(OP_RX, sb.closing_bcc());

    // Random part, split into phases with a new initial baud rate each.
    // The third phase carries the long receiver stall; the last runs flat out.
    for (int p = 0; p < PHASES; p++) begin
      write_initial_baud(baud_plan[p]);
      quiet = (p == PHASES - 1);
      if (p == 2) hold_req = 1'b1;
      goal = (p + 1) * EVENT_GOAL / PHASES;
      while (sb.events_taken < goal) run_readout();
    end

    drain_results();
    $display("Covered %0d input words (%0d acted on) and %0d output words, %0d baud settings.",
             sb.events_taken, sb.events_used, sb.words_checked, PHASES + 1);
    $display("Readouts closed: %0d ok, %0d protocol errors, %0d checksum errors.",
             sb.ok_total, sb.proto_total, sb.bcc_total);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
